>>> src/tsf_pkg.sv
package tsf_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEF      = 16;
    localparam int ENTRY_BITS_DEF = 32;
    localparam int TIME_BITS_DEF  = 48;

    // Fixed field widths.
    localparam int TIMEOUT_W = 32;
    localparam int CNT_W     = 5;
    localparam int STATUS_W  = 3;

    // Reset value of the timeout register, in milliseconds.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;

    // Most result items that one get may produce.
    localparam int MAX_RESULTS = 16;

    // Operation codes carried in the input tuser.
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_PUT_OK    = 3'd0,
        ST_PUT_FULL  = 3'd1,
        ST_ENTRY     = 3'd2,
        ST_NONE      = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

endpackage

>>> src/timestamped_fifo_with_expiry.sv
// Timestamped FIFO with age expiry. A put (tuser = 0) stores the entry with
// its now_ms stamp and answers with one transfer, status 0, or status 1 when
// all DEPTH slots are taken. A get (tuser = 1) first drops, oldest first,
// every entry whose stamp is at or before now_ms minus the timeout register,
// then returns the surviving entries newest first, up to max_entries (and at
// most 16), tlast on the final one. A get on an empty store, or one whose
// entries all expire, gives one status 3 transfer, a get with max_entries = 0
// one status 4 transfer. Each step of the sequencer waits on the registered
// read of the entry and stamp RAMs, and output stalls hold it as well. The
// input is not ready while a get is in progress. The timeout must be written
// only while the block is idle; the block itself does not enforce this, and
// the configuration channel is always ready. No clearing pass follows reset.
module timestamped_fifo_with_expiry
    import tsf_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Timeout register write channel.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [TIMEOUT_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // tdata from bit 0: entry_data, now_ms, max_entries, zero fill.
    input  logic [((ENTRY_BITS + TIME_BITS + CNT_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: operation.
    input  logic                     i_s_tuser,
    // Output stream.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // tdata from bit 0: entry_data_res, stored_count, zero fill.
    output logic [((ENTRY_BITS + CNT_W + 7) / 8) * 8 - 1:0] o_m_tdata,
    // tuser: status.
    output logic [STATUS_W-1:0]      o_m_tuser,
    output logic                     o_m_tlast
);

    localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int NW     = (CW > CNT_W) ? CW : CNT_W;
    localparam int SW     = $clog2(2 * DEPTH) + 1;
    localparam int OUT_W  = ((ENTRY_BITS + CNT_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXP_RD   = 5'b00010,
        S_EXP_CHK  = 5'b00100,
        S_OUT_RD   = 5'b01000,
        S_OUT_EMIT = 5'b10000
    } t_state;

    // Input fields.
    logic [ENTRY_BITS-1:0] w_in_data;
    logic [TIME_BITS-1:0]  w_in_now;
    logic [CNT_W-1:0]      w_in_want;

    assign w_in_data = i_s_tdata[ENTRY_BITS-1:0];
    assign w_in_now  = i_s_tdata[ENTRY_BITS+TIME_BITS-1:ENTRY_BITS];
    assign w_in_want = i_s_tdata[ENTRY_BITS+TIME_BITS+CNT_W-1:ENTRY_BITS+TIME_BITS];

    // Control and working registers.
    t_state                r_state,   n_state;
    logic [PW-1:0]         r_newest,  n_newest;
    logic [CW-1:0]         r_count,   n_count;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [TIME_BITS-1:0]  r_now,     n_now;
    logic [CNT_W-1:0]      r_want,    n_want;
    logic [NW-1:0]         r_n,       n_n;
    logic [NW-1:0]         r_k,       n_k;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    t_status               r_status,    n_status;
    logic [ENTRY_BITS-1:0] r_data,      n_data;
    logic                  r_last,      n_last;
    logic [CNT_W-1:0]      r_cnt,       n_cnt;

    // RAM ports.
    logic                  w_we;
    logic                  w_re;
    logic [PW-1:0]         w_waddr;
    logic [PW-1:0]         w_raddr;
    logic [ENTRY_BITS-1:0] w_rd_entry;
    logic [TIME_BITS-1:0]  w_rd_stamp;
    logic                  w_expired;

    logic                  w_out_free;
    logic                  w_in_xfer;
    logic [PW-1:0]         w_next_slot;
    logic [SW-1:0]         w_old_sum;
    logic [SW-1:0]         w_new_sum;
    logic [PW-1:0]         w_oldest;
    logic [PW-1:0]         w_kth;
    logic [NW-1:0]         w_lim;
    logic [NW-1:0]         w_take;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer   = i_s_tvalid && o_s_tready;

    // Slot arithmetic modulo DEPTH; each sum stays at or below twice DEPTH.
    assign w_next_slot = (r_newest == PW'(DEPTH - 1)) ? '0 : r_newest + PW'(1);
    assign w_old_sum   = SW'(r_newest) + SW'(DEPTH + 1) - SW'(r_count);
    assign w_oldest    = (w_old_sum >= SW'(DEPTH)) ? PW'(w_old_sum - SW'(DEPTH))
                                                   : PW'(w_old_sum);
    assign w_new_sum   = SW'(r_newest) + SW'(DEPTH) - SW'(r_k);
    assign w_kth       = (w_new_sum >= SW'(DEPTH)) ? PW'(w_new_sum - SW'(DEPTH))
                                                   : PW'(w_new_sum);

    // Number of results: the request, limited to the holdings and to the cap.
    assign w_lim  = (NW'(r_want) < NW'(r_count)) ? NW'(r_want) : NW'(r_count);
    assign w_take = (w_lim > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : w_lim;

    assign w_waddr = w_next_slot;
    assign w_raddr = (r_state == S_EXP_RD) ? w_oldest : w_kth;

    tsf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_entry)
    );

    tsf_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_now),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_stamp)
    );

    tsf_age_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_age_cmp (
        .i_stamp   (w_rd_stamp),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_expired (w_expired)
    );

    // Sequencer: puts and zero-count gets finish in the idle state, other gets walk
    // the expired tail and then the fresh entries from the newest slot back.
    always_comb begin
        n_state     = r_state;
        n_newest    = r_newest;
        n_count     = r_count;
        n_now       = r_now;
        n_want      = r_want;
        n_n         = r_n;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_data      = r_data;
        n_last      = r_last;
        n_cnt       = r_cnt;
        w_we        = 1'b0;
        w_re        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_last      = 1'b1;
                    n_cnt       = CNT_W'(r_count);
                    if (i_s_tuser == OP_PUT) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = ST_PUT_FULL;
                        end else begin
                            w_we     = 1'b1;
                            n_newest = w_next_slot;
                            n_count  = r_count + CW'(1);
                            n_status = ST_PUT_OK;
                            n_cnt    = CNT_W'(r_count + CW'(1));
                        end
                    end else if (w_in_want == '0) begin
                        n_status = ST_TOO_SMALL;
                    end else begin
                        n_out_valid = r_out_valid && !i_m_tready;
                        n_now       = w_in_now;
                        n_want      = w_in_want;
                        n_state     = S_EXP_RD;
                    end
                end
            end
            S_EXP_RD: begin
                if (r_count == '0) begin
                    // The output register is free: nothing was loaded since
                    // this get was taken.
                    n_out_valid = 1'b1;
                    n_status    = ST_NONE;
                    n_data      = '0;
                    n_last      = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    n_state = S_EXP_CHK;
                end
            end
            S_EXP_CHK: begin
                if (w_expired) begin
                    n_count = r_count - CW'(1);
                    n_state = S_EXP_RD;
                end else begin
                    n_n     = w_take;
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                w_re    = 1'b1;
                n_state = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_ENTRY;
                    n_data      = w_rd_entry;
                    n_last      = (r_k + NW'(1) == r_n);
                    n_cnt       = CNT_W'(r_count);
                    n_k         = r_k + NW'(1);
                    n_state     = (r_k + NW'(1) == r_n) ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newest    <= '0;
            r_count     <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_want   <= n_want;
        r_n      <= n_n;
        r_k      <= n_k;
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
        r_cnt    <= n_cnt;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = OUT_W'({r_cnt, r_data});

    // The number of held entries never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("held count exceeds depth");

    // A put transfer always produces its single result in the next cycle.
    a_put_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == OP_PUT) |=> (o_m_tvalid && o_m_tlast))
        else $error("put without a result");

    // An emitted entry comes from a non-empty store.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_ENTRY) |-> (r_cnt != '0))
        else $error("entry returned from an empty store");

    // While emitting, the result index stays below the result count.
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_EMIT) |-> (r_k < r_n))
        else $error("result index out of range");

endmodule

>>> src/tsf_ram.sv
module tsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> src/tsf_age_cmp.sv
module tsf_age_cmp
    import tsf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0] i_stamp,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    output logic                 o_expired
);

    localparam int EW = (TIME_BITS > TIMEOUT_W ? TIME_BITS : TIMEOUT_W) + 1;

    logic [EW-1:0] w_deadline;

    // An entry is stale when stamp + timeout <= now. This can only hold when
    // now is at least the timeout, so no separate guard is needed.
    assign w_deadline = EW'(i_stamp) + EW'(i_timeout);
    assign o_expired  = (w_deadline <= EW'(i_now));

endmodule

>>> bench/tb_timestamped_fifo_with_expiry.sv
`timescale 1ns / 100ps

import tsf_pkg::*;

// One result transfer as the block should produce it.
typedef struct {
    t_status                   status;
    logic [ENTRY_BITS_DEF-1:0] data;
    logic                      last;
    logic [CNT_W-1:0]          count;
} t_fifo_reply;

// Tracks the contents of the stamped store and the replies that are due.
class stamped_store_tracker;
    localparam int PTR_W = $clog2(DEPTH_DEF);

    logic [ENTRY_BITS_DEF-1:0] entry_mem [DEPTH_DEF];
    logic [TIME_BITS_DEF-1:0]  stamp_mem [DEPTH_DEF];
    logic [PTR_W-1:0]          newest_slot;
    logic [CNT_W-1:0]          held;
    logic [TIMEOUT_W-1:0]      age_limit;
    t_fifo_reply               due_replies [$];
    int                        errors;

    function new();
        newest_slot = '0;
        held        = '0;
        age_limit   = TIMEOUT_RESET;
        errors      = 0;
    endfunction

    function void set_timeout(logic [TIMEOUT_W-1:0] value);
        age_limit = value;
    endfunction

    // Every reply reports the holdings after the operation.
    function void add_reply(t_status st, logic [ENTRY_BITS_DEF-1:0] d, logic lst);
        t_fifo_reply r;
        r.status = st;
        r.data   = d;
        r.last   = lst;
        r.count  = held;
        due_replies.push_back(r);
    endfunction

    // Work out the replies caused by one accepted request.
    function void note_request(logic op, logic [ENTRY_BITS_DEF-1:0] data,
                               logic [TIME_BITS_DEF-1:0] now, logic [CNT_W-1:0] want);
        logic [PTR_W-1:0]         slot;
        logic [TIME_BITS_DEF-1:0] limit;
        int                       n;
        bit                       done;
        if (op == OP_PUT) begin
            if (held >= DEPTH_DEF) begin
                add_reply(ST_PUT_FULL, '0, 1'b1);
            end else begin
                slot            = newest_slot + PTR_W'(1);
                entry_mem[slot] = data;
                stamp_mem[slot] = now;
                newest_slot     = slot;
                held            = held + 1'b1;
                add_reply(ST_PUT_OK, '0, 1'b1);
            end
        end else if (want == '0) begin
            add_reply(ST_TOO_SMALL, '0, 1'b1);
        end else begin
            // Drop expired entries from the oldest end; no expiry while now
            // is still below the timeout.
            if (held > 0 && now >= TIME_BITS_DEF'(age_limit)) begin
                limit = now - TIME_BITS_DEF'(age_limit);
                done  = 1'b0;
                while (held > 0 && !done) begin
                    slot = newest_slot + PTR_W'(1) - PTR_W'(held);
                    if (stamp_mem[slot] > limit) begin
                        done = 1'b1;
                    end else begin
                        held = held - 1'b1;
                    end
                end
            end
            if (held == 0) begin
                add_reply(ST_NONE, '0, 1'b1);
            end else begin
                n = (want < held) ? int'(want) : int'(held);
                if (n > MAX_RESULTS) begin
                    n = MAX_RESULTS;
                end
                for (int k = 0; k < n; k++) begin
                    slot = newest_slot - PTR_W'(k);
                    add_reply(ST_ENTRY, entry_mem[slot], k == n - 1);
                end
            end
        end
    endfunction

    // Compare one result transfer with the oldest reply that is due.
    function void check_result(t_status st, logic [ENTRY_BITS_DEF-1:0] d, logic lst,
                               logic [CNT_W-1:0] cnt);
        t_fifo_reply head;
        if (due_replies.size() == 0) begin
            errors++;
            $display("%0t: result with nothing due: status %0d data %h last %b count %0d",
                     $time, st, d, lst, cnt);
            return;
        end
        head = due_replies.pop_front();
        if (st !== head.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, head.status, st);
        end
        if (d !== head.data) begin
            errors++;
            $display("%0t: entry data expected %h actual %h", $time, head.data, d);
        end
        if (lst !== head.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, head.last, lst);
        end
        if (cnt !== head.count) begin
            errors++;
            $display("%0t: stored count expected %0d actual %0d", $time, head.count, cnt);
        end
    endfunction
endclass

module tb_timestamped_fifo_with_expiry;

    localparam int IN_W      = ((ENTRY_BITS_DEF + TIME_BITS_DEF + CNT_W + 7) / 8) * 8;
    localparam int OUT_W     = ((ENTRY_BITS_DEF + CNT_W + 7) / 8) * 8;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYC = 80;
    localparam int PHASE_LEN = 22;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TIMEOUT_W-1:0] i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;
    logic                 o_m_tlast;

    stamped_store_tracker     tracker;
    bit                       hold_off_req = 1'b0;
    int                       send_quiet   = 0;
    int                       recv_quiet   = 0;
    logic [TIME_BITS_DEF-1:0] cur_time     = '0;

    timestamped_fifo_with_expiry u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Idle cycles before a transfer, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Offer one request and wait for its transfer.
    task automatic send_item(logic op, logic [ENTRY_BITS_DEF-1:0] data,
                             logic [TIME_BITS_DEF-1:0] now, logic [CNT_W-1:0] want);
        int gap;
        gap = draw_wait(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(IN_W - ENTRY_BITS_DEF - TIME_BITS_DEF - CNT_W){1'b0}},
                       want, now, data};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        tracker.note_request(op, data, now, want);
    endtask

    // Random request around a moving time base, with now sometimes thrown anywhere.
    task automatic random_item(logic [31:0] step_max);
        logic                      op;
        logic [ENTRY_BITS_DEF-1:0] data;
        logic [TIME_BITS_DEF-1:0]  now;
        logic [CNT_W-1:0]          want;
        int                        pick;
        op       = ($urandom_range(0, 9) < 6) ? OP_PUT : OP_GET;
        data     = $urandom;
        cur_time = cur_time + TIME_BITS_DEF'($urandom_range(0, step_max));
        now      = cur_time;
        if ($urandom_range(0, 15) == 0) begin
            now = TIME_BITS_DEF'({$urandom, $urandom});
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            want = '0;
        end else if (pick == 1) begin
            want = CNT_W'($urandom_range(17, 31));
        end else begin
            want = CNT_W'($urandom_range(1, 16));
        end
        send_item(op, data, now, want);
    endtask

    // Stop offering, wait for every due reply, then let the block go quiet.
    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (tracker.due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Timeout register write; only called while the block is idle.
    task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_timeout(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold-off on request.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                gap = draw_wait(recv_quiet);
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            tracker.check_result(t_status'(o_m_tuser), o_m_tdata[ENTRY_BITS_DEF-1:0],
                                 o_m_tlast, o_m_tdata[ENTRY_BITS_DEF +: CNT_W]);
        end
    end

    // Stimulus.
    initial begin
        logic [TIMEOUT_W-1:0] tmo;
        tracker = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gets on an empty store: zero count, then nothing found.
        send_item(OP_GET, '0, '0, 5'd0);
        send_item(OP_GET, '1, '0, 5'd1);
        // Fill the store with stamps 0 to 15, then overfill it.
        for (int i = 0; i < DEPTH_DEF; i++) begin
            send_item(OP_PUT, (i == 0) ? '0 : (i == 1) ? '1 : $urandom,
                      TIME_BITS_DEF'(i), CNT_W'($urandom_range(0, 31)));
        end
        send_item(OP_PUT, $urandom, '1, 5'd0);
        // Zero count on a full store discards nothing.
        send_item(OP_GET, '0, '1, 5'd0);
        // Now below the timeout with a count above the holdings.
        send_item(OP_GET, '0, 48'd999, 5'd31);
        // Stamps at or before now minus the timeout expire.
        send_item(OP_GET, '0, 48'd1005, 5'd3);
        send_item(OP_PUT, $urandom, 48'd2000, 5'd16);
        // Every entry expires at once.
        send_item(OP_GET, '0, '1, 5'd16);
        drain();

        // Random phases, each under its own timeout.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    tmo = '0;
                end
                1: begin
                    tmo = 32'd37;
                end
                2: begin
                    tmo = '1;
                end
                default: begin
                    tmo = $urandom_range(1, 5000);
                end
            endcase
            // The result side stalls for a long stretch while requests keep coming.
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            write_timeout(tmo);
            cur_time = TIME_BITS_DEF'($urandom_range(0, 1000));
            repeat (PHASE_LEN) random_item(tmo / 8 + 3);
            drain();
        end

        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/tsf_pkg.sv
src/tsf_ram.sv
src/tsf_age_cmp.sv
src/timestamped_fifo_with_expiry.sv
bench/tb_timestamped_fifo_with_expiry.sv
